>>> design/b64u_pkg.sv
// shared types, constants and the character lookup for the base64url stream decoder
`timescale 1ns / 1ps

package b64u_pkg;

  localparam logic [7:0] PadChar = 8'd61;
  localparam logic [5:0] SextetDash = 6'd62;
  localparam logic [5:0] SextetUnder = 6'd63;

  // group collection state
  typedef struct packed {
    logic [2:0][5:0] sextets;
    logic [2:0]      sextet_ok;
    logic [1:0]      pos;
    logic            third_pad;
    logic            discard;
  } grp_state_t;

  // one decoded group: up to three bytes sent one beat at a time
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
    logic            err;
  } res_grp_t;

  // result of looking up one character
  typedef struct packed {
    logic [5:0] val;
    logic       ok;
  } sextet_t;

  // url-safe alphabet lookup, anything else is invalid with value zero
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.ok  = 1'b1;
    r.val = '0;
    case (c) inside
      [8'd65 : 8'd90]:  r.val = 6'(c - 8'd65);
      [8'd97 : 8'd122]: r.val = 6'(c - 8'd71);
      [8'd48 : 8'd57]:  r.val = 6'(c + 8'd4);
      8'd45:            r.val = SextetDash;
      8'd95:            r.val = SextetUnder;
      default:          r.ok  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> design/b64u_group_dec.sv
// combinational step of the decoder: state update and result group for one character
`timescale 1ns / 1ps

module b64u_group_dec import b64u_pkg::*; (
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  input  grp_state_t st_i,
  output grp_state_t st_o,
  output logic       emit_o,
  output res_grp_t   res_o
);

  sextet_t    cur;
  logic       fourth_pad;
  logic       good;
  logic [1:0] n;
  grp_state_t cleared;

  assign cur = sextet_of(char_code_i);
  assign fourth_pad = (char_code_i == PadChar);

  always_comb begin
    cleared = '0;
    cleared.discard = st_i.discard;
  end

  // group check on the fourth character
  always_comb begin
    if (st_i.third_pad && fourth_pad) begin
      good = st_i.sextet_ok[0] & st_i.sextet_ok[1];
      n    = 2'd1;
    end else if (fourth_pad) begin
      good = &st_i.sextet_ok;
      n    = 2'd2;
    end else begin
      good = (&st_i.sextet_ok) & cur.ok;
      n    = 2'd3;
    end
  end

  // next state and result
  always_comb begin
    st_o   = st_i;
    emit_o = 1'b0;
    res_o  = '0;
    if (st_i.discard) begin
      if (last_char_i) begin
        st_o = '0;
      end
    end else if (st_i.pos != 2'd3) begin
      st_o.sextets[st_i.pos]   = cur.val;
      st_o.sextet_ok[st_i.pos] = cur.ok;
      if (st_i.pos == 2'd2) begin
        st_o.third_pad = fourth_pad;
      end
      st_o.pos = st_i.pos + 2'd1;
      if (last_char_i) begin
        // short message
        st_o      = cleared;
        emit_o    = 1'b1;
        res_o.cnt = 2'd1;
        res_o.last = 1'b1;
        res_o.err  = 1'b1;
      end
    end else begin
      st_o   = cleared;
      emit_o = 1'b1;
      if (!good) begin
        res_o.cnt    = 2'd1;
        res_o.last   = 1'b1;
        res_o.err    = 1'b1;
        st_o.discard = ~last_char_i;
      end else begin
        res_o.bytes[0] = {st_i.sextets[0], st_i.sextets[1][5:4]};
        res_o.bytes[1] = {st_i.sextets[1][3:0], st_i.sextets[2][5:2]};
        res_o.bytes[2] = {st_i.sextets[2][1:0], cur.val};
        res_o.cnt      = n;
        res_o.last     = last_char_i;
      end
    end
  end

endmodule

>>> design/base64url_stream_decoder_unit.sv
// top level of the base64url stream decoder: beat handshakes and result buffering
//
// Input channel: one character per beat (char_code_i, last_char_i on the final
// character of a message), handshake in_valid_i / in_ready_o.
// Output channel: one decoded byte per beat (data_byte_o, last_byte_o, error_o),
// handshake out_valid_o / out_ready_i.
// A character is decoded in the cycle it is taken; a group's bytes are held in a
// result register and, when no earlier group is still draining, show up on the
// output from the next cycle on, one per cycle while out_ready_i is high.
// Throughput is one character per cycle while in_ready_o is high: a group of four
// characters gives at most three bytes, drained while the next group comes in.
// A second result register holds one more group while the first still drains;
// in_ready_o drops while that second register is full. That happens when the
// receiver stalls, or when a short or broken message ends right behind a
// multi-byte group; the input is then held until the first register's last
// byte goes out.
// Errors give one beat with error_o and last_byte_o set and a zero byte; the
// rest of the message is then dropped up to its last character.
// Reset clears the group state, the drop mode and both result valid flags.
`timescale 1ns / 1ps

module base64url_stream_decoder_unit import b64u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       last_byte_o,
  output logic       error_o
);

  grp_state_t st_q, st_d;
  res_grp_t   a_q, b_q, new_res;
  logic       a_valid_q, b_valid_q;
  logic [1:0] idx_q;
  logic       in_beat, out_beat, a_done, a_free, emit;

  b64u_group_dec u_dec (
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .st_i        (st_q),
    .st_o        (st_d),
    .emit_o      (emit),
    .res_o       (new_res)
  );

  // handshakes
  assign in_ready_o = ~b_valid_q;
  assign in_beat    = in_valid_i & in_ready_o;
  assign out_valid_o = a_valid_q;
  assign out_beat   = a_valid_q & out_ready_i;
  assign a_done     = out_beat & (idx_q == a_q.cnt - 2'd1);
  assign a_free     = ~a_valid_q | a_done;

  // output beat from the draining group
  assign data_byte_o = a_q.bytes[idx_q];
  assign last_byte_o = a_q.last & (idx_q == a_q.cnt - 2'd1);
  assign error_o     = a_q.err;

  // group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (in_beat) begin
      st_q <= st_d;
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      idx_q     <= '0;
    end else if (a_free) begin
      idx_q <= '0;
      if (b_valid_q) begin
        a_valid_q <= 1'b1;
        b_valid_q <= 1'b0;
      end else begin
        a_valid_q <= in_beat & emit;
      end
    end else begin
      if (out_beat) begin
        idx_q <= idx_q + 2'd1;
      end
      if (in_beat && emit) begin
        b_valid_q <= 1'b1;
      end
    end
  end

  // result payloads
  always_ff @(posedge clk_i) begin
    if (a_free) begin
      if (b_valid_q) begin
        a_q <= b_q;
      end else if (in_beat && emit) begin
        a_q <= new_res;
      end
    end else if (in_beat && emit) begin
      b_q <= new_res;
    end
  end

  // a queued group implies one draining ahead of it
  assert property (@(posedge clk_i) disable iff (!rst_ni) b_valid_q |-> a_valid_q)
    else $error("second result register full while first is empty");

  // a shown group has one to three bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (a_q.cnt != 2'd0 && idx_q < a_q.cnt))
    else $error("result beat index out of range");

  // error beats are single, final and zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (last_byte_o && data_byte_o == 8'd0))
    else $error("error beat not final or not zero");

  // a stalled output group keeps its index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(idx_q)))
    else $error("stalled result beat moved");

endmodule

>>> tb/base64url_stream_decoder_unit_tb.sv
// self-checking testbench for the base64url stream decoder, with a built-in predictor
`timescale 1ns / 1ps

module base64url_stream_decoder_unit_tb;
  import b64u_pkg::*;

  // one character beat on the input side
  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_beat_t;

  // one decoded beat on the output side
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       err;
  } byte_beat_t;

  localparam int unsigned CalmTail = 60;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_code_i = 8'd0;
  logic       last_char_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] data_byte_o;
  logic       last_byte_o;
  logic       error_o;

  char_beat_t pending_chars[$];
  byte_beat_t expected_bytes[$];

  // predictor copy of the group state
  logic [5:0] grp_val[3];
  logic       grp_ok[3];
  logic [1:0] grp_pos;
  logic       pad_third;
  logic       dropping;

  int unsigned fail_count = 0;
  int unsigned msg_count = 0;
  int unsigned chars_taken = 0;
  int unsigned bytes_seen = 0;
  int unsigned errors_seen = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          calm;

  base64url_stream_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_byte_o (data_byte_o),
    .last_byte_o (last_byte_o),
    .error_o     (error_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // alphabet lookup: {ok, value}
  function automatic logic [6:0] decode_char(input logic [7:0] c);
    if (c >= 8'd65 && c <= 8'd90) return {1'b1, 6'(c - 8'd65)};
    if (c >= 8'd97 && c <= 8'd122) return {1'b1, 6'(c - 8'd97 + 8'd26)};
    if (c >= 8'd48 && c <= 8'd57) return {1'b1, 6'(c - 8'd48 + 8'd52)};
    if (c == 8'd45) return {1'b1, SextetDash};
    if (c == 8'd95) return {1'b1, SextetUnder};
    return 7'd0;
  endfunction

  // sextet value back to its character
  function automatic logic [7:0] alpha_char(input int unsigned idx);
    if (idx < 26) return 8'(65 + idx);
    if (idx < 52) return 8'(97 + idx - 26);
    if (idx < 62) return 8'(48 + idx - 52);
    if (idx == 62) return 8'd45;
    return 8'd95;
  endfunction

  function automatic void clear_group();
    for (int i = 0; i < 3; i++) begin
      grp_val[i] = '0;
      grp_ok[i]  = 1'b0;
    end
    grp_pos   = '0;
    pad_third = 1'b0;
  endfunction

  function automatic void push_byte(input logic [7:0] d, input logic l, input logic e);
    byte_beat_t b;
    b.data = d;
    b.last = l;
    b.err  = e;
    expected_bytes.push_back(b);
  endfunction

  // expected bytes for one accepted character
  function automatic void predict_char(input logic [7:0] code, input logic last);
    logic [6:0] lk;
    logic       fourth_pad;
    logic       good;
    logic [7:0] b[3];
    int         n;
    lk = decode_char(code);
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        clear_group();
      end
      return;
    end
    if (grp_pos != 2'd3) begin
      grp_val[grp_pos] = lk[5:0];
      grp_ok[grp_pos]  = lk[6];
      if (grp_pos == 2'd2) pad_third = (code == PadChar);
      grp_pos = grp_pos + 2'd1;
      // message ends inside a group
      if (last) begin
        clear_group();
        push_byte(8'd0, 1'b1, 1'b1);
      end
      return;
    end
    fourth_pad = (code == PadChar);
    if (pad_third && fourth_pad) begin
      good = grp_ok[0] && grp_ok[1];
      n = 1;
    end else if (fourth_pad) begin
      good = grp_ok[0] && grp_ok[1] && grp_ok[2];
      n = 2;
    end else begin
      good = grp_ok[0] && grp_ok[1] && grp_ok[2] && lk[6];
      n = 3;
    end
    b[0] = {grp_val[0], grp_val[1][5:4]};
    b[1] = {grp_val[1][3:0], grp_val[2][5:2]};
    b[2] = {grp_val[2][1:0], lk[5:0]};
    clear_group();
    if (!good) begin
      push_byte(8'd0, 1'b1, 1'b1);
      if (!last) dropping = 1'b1;
      return;
    end
    for (int k = 0; k < n; k++) push_byte(b[k], last && (k == n - 1), 1'b0);
  endfunction

  task automatic queue_msg(input logic [7:0] msg[$]);
    char_beat_t c;
    for (int i = 0; i < msg.size(); i++) begin
      c.code = msg[i];
      c.last = (i == msg.size() - 1);
      pending_chars.push_back(c);
    end
    msg_count++;
  endtask

  task automatic queue_text(input string s);
    logic [7:0] msg[$];
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    queue_msg(msg);
  endtask

  // one random group, with the given number of trailing pads
  task automatic add_group(inout logic [7:0] msg[$], input int unsigned pads);
    for (int i = 0; i < 4; i++)
      msg.push_back((i >= 4 - pads) ? PadChar : alpha_char($urandom_range(0, 63)));
  endtask

  // random message: mostly well formed, the rest broken or noise
  task automatic queue_random_msg();
    logic [7:0]  msg[$];
    int unsigned kind;
    int unsigned groups;
    int unsigned cut;
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      groups = $urandom_range(1, 4);
      for (int g = 0; g < groups; g++) begin
        if (g == groups - 1) add_group(msg, $urandom_range(0, 2));
        else if ($urandom_range(0, 7) == 0) add_group(msg, $urandom_range(1, 2));
        else add_group(msg, 0);
      end
      // corrupt one character
      if (kind == 6) msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
      // break the length
      if (kind == 7) begin
        cut = $urandom_range(1, 3);
        for (int i = 0; i < cut; i++) void'(msg.pop_back());
        if (msg.size() == 0) msg.push_back(alpha_char($urandom_range(0, 63)));
      end
    end else if (kind == 8) begin
      // raw noise of any byte value
      repeat ($urandom_range(1, 9)) msg.push_back(8'($urandom_range(0, 255)));
    end else begin
      // pads anywhere in the group
      repeat (4 * $urandom_range(1, 2))
        msg.push_back(($urandom_range(0, 2) == 0) ? PadChar : alpha_char($urandom_range(0, 63)));
    end
    queue_msg(msg);
  endtask

  assign calm = (pending_chars.size() < CalmTail);

  // input driver
  always @(posedge clk_i) begin
    char_beat_t c;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_char(char_code_i, last_char_i);
        chars_taken++;
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the beat until taken
      end else if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_chars.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 6);
        in_valid_i <= 1'b0;
      end else if (pending_chars.size() != 0) begin
        c = pending_chars.pop_front();
        char_code_i <= c.code;
        last_char_i <= c.last;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk_i) begin
    byte_beat_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        bytes_seen++;
        if (error_o) errors_seen++;
        if (expected_bytes.size() == 0) begin
          report($sformatf("unexpected beat data=%02h last=%0b err=%0b",
                           data_byte_o, last_byte_o, error_o));
        end else begin
          e = expected_bytes.pop_front();
          if (data_byte_o !== e.data)
            report($sformatf("data_byte %02h, expected %02h", data_byte_o, e.data));
          if (last_byte_o !== e.last)
            report($sformatf("last_byte %0b, expected %0b", last_byte_o, e.last));
          if (error_o !== e.err)
            report($sformatf("error %0b, expected %0b", error_o, e.err));
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 6);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned waited;
    logic [7:0]  msg[$];
    clear_group();
    dropping = 1'b0;

    // directed: pad group mid-message, then alphabet extremes
    queue_text("TQ==_-9z");
    queue_text("TWFu");
    queue_text("TWE=");
    queue_text("AAAA");
    // message ending inside a group
    queue_text("AB");
    // pad in third place, data in fourth
    queue_text("AB=C");
    // bad character early, rest of the message dropped
    msg = '{8'hff, 8'h41, 8'h43, 8'h44, 8'h00, 8'h80};
    queue_msg(msg);

    while (pending_chars.size() < 430) queue_random_msg();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || in_valid_i) @(posedge clk_i);
    waited = 0;
    while (expected_bytes.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (expected_bytes.size() != 0)
      report($sformatf("%0d expected beats never arrived", expected_bytes.size()));

    $display("covered %0d messages, %0d characters in, %0d beats out (%0d error beats)",
             msg_count, chars_taken, bytes_seen, errors_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
design/b64u_pkg.sv
design/b64u_group_dec.sv
design/base64url_stream_decoder_unit.sv
tb/base64url_stream_decoder_unit_tb.sv
